// ----- rtl/assert_macros.svh -----
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked every cycle outside reset.
`define ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, also checked across reset.
`define ASSERT_NEXT(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("assertion failed");

// Next-cycle implication checked outside reset.
`define ASSERT_NEXT_RST(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- rtl/lkv_pkg.sv -----
`default_nettype none
package lkv_pkg;

  localparam int DEPTH_DEFAULT = 16;
  localparam int CAP_W         = 5;
  localparam int KEY_W         = 32;
  localparam int VAL_W         = 32;

  localparam logic [CAP_W-1:0] CAP_RESET  = 5'd16;
  localparam logic [VAL_W-1:0] MISS_VALUE = '1;

  // operation codes carried in tuser
  localparam logic FUNC_GET = 1'b0;
  localparam logic FUNC_PUT = 1'b1;

  // one access presented to the entry store
  typedef struct packed {
    logic             go;
    logic             put;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
  } lkv_req_t;

endpackage
`default_nettype wire

// ----- rtl/lru_key_value_cache.sv -----
`default_nettype none
// Fully associative key-value cache with least-recently-used replacement.
// One access (get or put) is accepted per clock, sustained while the result
// output is not stalled. The access is registered, then the parallel key
// compare and rank update run and the result lands in the output register.
// An access sees every state change of the one before it.
// Write capacity (clamped to 1..DEPTH) only while no access is in flight.
// No clearing pass after reset: the block accepts accesses at once.
module lru_key_value_cache #(
  parameter int DEPTH = lkv_pkg::DEPTH_DEFAULT
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  // capacity register write
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [lkv_pkg::CAP_W-1:0]     cfg_data,
  // access input
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  input  wire logic [63:0]                   s_axis_tdata,  // lookup_key, write_value
  input  wire logic [0:0]                    s_axis_tuser,  // func
  // result output
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  output logic [31:0]                        m_axis_tdata,  // read_value
  output logic [1:0]                         m_axis_tuser   // hit, evicted
);

  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int CMP_W = (CNT_W > lkv_pkg::CAP_W) ? CNT_W : lkv_pkg::CAP_W;

  logic [lkv_pkg::CAP_W-1:0] capacity;

  logic                      in_valid;
  logic                      in_func;
  logic [lkv_pkg::KEY_W-1:0] in_key;
  logic [lkv_pkg::VAL_W-1:0] in_value;
  logic                      advance;

  logic                      res_hit;
  logic                      res_evicted;
  logic [lkv_pkg::VAL_W-1:0] res_value;

  logic [lkv_pkg::KEY_W-1:0] keys [DEPTH];
  logic [CNT_W-1:0]          ranks [DEPTH];
  logic [CNT_W-1:0]          count;
  logic [lkv_pkg::VAL_W-1:0] hit_value;
  logic                      hit;
  logic [IDX_W-1:0]          hit_idx;
  logic [IDX_W-1:0]          victim_idx;
  logic                      full;
  logic [CMP_W-1:0]          cap_min1;
  lkv_pkg::lkv_req_t         req;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= lkv_pkg::CAP_RESET;
    end else if (cfg_valid) begin
      capacity <= cfg_data;
    end
  end

  // input register
  assign advance       = in_valid && (!m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_func  <= s_axis_tuser[0];
      in_key   <= s_axis_tdata[31:0];
      in_value <= s_axis_tdata[63:32];
    end
  end

  // no free slot below the effective capacity
  assign cap_min1 = (capacity == '0) ? CMP_W'(1) : CMP_W'(capacity);
  assign full     = (CMP_W'(count) >= cap_min1) || (count == CNT_W'(DEPTH));

  assign req.go    = advance;
  assign req.put   = (in_func == lkv_pkg::FUNC_PUT);
  assign req.key   = in_key;
  assign req.value = in_value;

  lkv_match #(
    .DEPTH (DEPTH),
    .IDX_W (IDX_W),
    .CNT_W (CNT_W)
  ) u_match (
    .key        (in_key),
    .keys       (keys),
    .ranks      (ranks),
    .count      (count),
    .hit        (hit),
    .hit_idx    (hit_idx),
    .victim_idx (victim_idx)
  );

  lkv_store #(
    .DEPTH (DEPTH),
    .IDX_W (IDX_W),
    .CNT_W (CNT_W)
  ) u_store (
    .clk        (clk),
    .rst        (rst),
    .req        (req),
    .hit        (hit),
    .hit_idx    (hit_idx),
    .victim_idx (victim_idx),
    .full       (full),
    .keys       (keys),
    .ranks      (ranks),
    .count      (count),
    .hit_value  (hit_value)
  );

  // result fields
  always_comb begin
    res_hit     = hit;
    res_evicted = req.put && !hit && full;
    if (req.put) begin
      res_value = '0;
    end else if (hit) begin
      res_value = hit_value;
    end else begin
      res_value = lkv_pkg::MISS_VALUE;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (advance) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      m_axis_tdata <= res_value;
      m_axis_tuser <= {res_evicted, res_hit};
    end
  end

endmodule
`default_nettype wire

// ----- rtl/lkv_match.sv -----
`default_nettype none
// Parallel key compare and LRU victim select over the slots in use.
module lkv_match #(
  parameter int DEPTH = lkv_pkg::DEPTH_DEFAULT,
  parameter int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  parameter int CNT_W = $clog2(DEPTH + 1)
) (
  input  wire logic [lkv_pkg::KEY_W-1:0] key,
  input  wire logic [lkv_pkg::KEY_W-1:0] keys [DEPTH],
  input  wire logic [CNT_W-1:0]          ranks [DEPTH],
  input  wire logic [CNT_W-1:0]          count,
  output logic                           hit,
  output logic [IDX_W-1:0]               hit_idx,
  output logic [IDX_W-1:0]               victim_idx
);

  logic [CNT_W-1:0] last_rank;

  assign last_rank = count - CNT_W'(1);

  // keys in use are unique and ranks form a permutation, so an OR encode suffices
  always_comb begin
    hit        = 1'b0;
    hit_idx    = '0;
    victim_idx = '0;
    for (int j = 0; j < DEPTH; j++) begin
      if (CNT_W'(j) < count) begin
        if (keys[j] == key) begin
          hit     = 1'b1;
          hit_idx = hit_idx | IDX_W'(j);
        end
        if (ranks[j] == last_rank) begin
          victim_idx = victim_idx | IDX_W'(j);
        end
      end
    end
  end

endmodule
`default_nettype wire

// ----- rtl/lkv_store.sv -----
`default_nettype none
// Key, value and recency storage with the per-access update.
module lkv_store #(
  parameter int DEPTH = lkv_pkg::DEPTH_DEFAULT,
  parameter int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  parameter int CNT_W = $clog2(DEPTH + 1)
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire lkv_pkg::lkv_req_t         req,
  input  wire logic                      hit,
  input  wire logic [IDX_W-1:0]          hit_idx,
  input  wire logic [IDX_W-1:0]          victim_idx,
  input  wire logic                      full,
  output logic [lkv_pkg::KEY_W-1:0]      keys [DEPTH],
  output logic [CNT_W-1:0]               ranks [DEPTH],
  output logic [CNT_W-1:0]               count,
  output logic [lkv_pkg::VAL_W-1:0]      hit_value
);

  logic [lkv_pkg::VAL_W-1:0] values [DEPTH];
  logic                      upd;
  logic                      fill;
  logic                      replace;
  logic [IDX_W-1:0]          target;
  logic [CNT_W-1:0]          old_rank;

  assign hit_value = values[hit_idx];

  assign upd     = req.go && (hit || req.put);
  assign fill    = req.go && req.put && !hit && !full;
  assign replace = req.go && req.put && !hit && full;

  // slot touched by this access and the rank it leaves behind
  always_comb begin
    if (hit) begin
      target   = hit_idx;
      old_rank = ranks[hit_idx];
    end else if (fill) begin
      target   = count[IDX_W-1:0];
      old_rank = count;
    end else begin
      target   = victim_idx;
      old_rank = count - CNT_W'(1);
    end
  end

  // recency ranks and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int j = 0; j < DEPTH; j++) begin
        ranks[j] <= '0;
      end
      count <= '0;
    end else if (upd) begin
      for (int j = 0; j < DEPTH; j++) begin
        if (CNT_W'(j) < count && ranks[j] < old_rank) begin
          ranks[j] <= ranks[j] + CNT_W'(1);
        end
      end
      ranks[target] <= '0;
      if (fill) begin
        count <= count + CNT_W'(1);
      end
    end
  end

  // payload storage, no reset
  always_ff @(posedge clk) begin
    if (upd && req.put) begin
      values[target] <= req.value;
    end
    if (fill || replace) begin
      keys[target] <= req.key;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/lkv_checker.sv -----
`default_nettype none
`include "assert_macros.svh"
// Port-level checks on the result stream.
module lkv_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [31:0] m_axis_tdata,
  input wire logic [1:0]  m_axis_tuser
);

  // an eviction only happens on a put that missed
  `ASSERT_IMP(a_evict_no_hit, clk, rst, m_axis_tvalid && m_axis_tuser[1], !m_axis_tuser[0])

  // an eviction returns zero
  `ASSERT_IMP(a_evict_zero, clk, rst, m_axis_tvalid && m_axis_tuser[1], m_axis_tdata == '0)

  // a miss returns zero (put) or all ones (get)
  `ASSERT_IMP(a_miss_value, clk, rst, m_axis_tvalid && !m_axis_tuser[0], m_axis_tdata == '0 || m_axis_tdata == '1)

  // no result right after reset
  `ASSERT_NEXT(a_reset_idle, clk, rst, !m_axis_tvalid)

  // a stalled result holds
  `ASSERT_NEXT_RST(a_hold, clk, rst, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))

endmodule

bind lru_key_value_cache lkv_checker u_lkv_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
`default_nettype wire
